### rtl/core/shs_pkg.sv
// shs_pkg: shared types, constants and the half-step coil table
// for the stepper half-step controller; no dependencies
package shs_pkg;

  localparam int unsigned KeyW    = 5;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned KeyFwd    = 0;
  localparam int unsigned KeyRev    = 1;
  localparam int unsigned KeyFaster = 2;
  localparam int unsigned KeySlower = 3;
  localparam int unsigned KeyRun    = 4;

  localparam logic [PeriodW-1:0] FastestReset = PeriodW'(1);
  localparam logic [PeriodW-1:0] SlowestReset = PeriodW'(5);
  localparam logic [PeriodW-1:0] PeriodReset  = PeriodW'(1);
  localparam logic [PhaseW-1:0]  LastPhase    = PhaseW'(7);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FASTEST = 1'b0,
    REG_SLOWEST = 1'b1
  } shs_reg_e;

  typedef struct packed {
    logic               dir;
    logic               run;
    logic [PeriodW-1:0] period;
  } shs_ctrl_t;

  function automatic logic [CoilW-1:0] half_step_coils(input logic [PhaseW-1:0] idx);
    logic [CoilW-1:0] c;
    unique case (idx)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/shs_ifs.sv
// shs_ifs: valid/ready channel interfaces for tick items, result items
// and register writes; depends on shs_pkg
interface shs_tick_if;
  logic                             valid;
  logic                             ready;
  logic [shs_pkg::KeyW-1:0]         key_levels;
  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface shs_result_if;
  logic                             valid;
  logic                             ready;
  logic [shs_pkg::CoilW-1:0]        coils;
  logic                             forward_led_level;
  logic                             reverse_led_level;
  logic                             running_now;
  modport source (output valid, output coils, output forward_led_level,
                  output reverse_led_level, output running_now, input ready);
  modport sink   (input valid, input coils, input forward_led_level,
                  input reverse_led_level, input running_now, output ready);
endinterface

interface shs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [shs_pkg::CfgIdxW-1:0]      index;
  logic [shs_pkg::PeriodW-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/shs_in_reg.sv
// shs_in_reg: input register holding one tick item
// depends on shs_pkg and shs_tick_if
module shs_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  shs_tick_if.sink                 tick_i,
  input  logic                     adv_i,
  output logic                     valid_o,
  output logic [shs_pkg::KeyW-1:0] levels_o
);
  import shs_pkg::*;

  logic            valid_q, valid_d;
  logic [KeyW-1:0] levels_q;
  logic            fire;

  assign tick_i.ready = !valid_q || adv_i;
  assign fire         = tick_i.valid && tick_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      levels_q <= tick_i.key_levels;
    end
  end

  assign valid_o  = valid_q;
  assign levels_o = levels_q;

endmodule

### rtl/core/shs_key_ctrl.sv
// shs_key_ctrl: key arming, key actions and period limit registers
// depends on shs_pkg and shs_cfg_if
module shs_key_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  shs_cfg_if.sink                  cfg_i,
  input  logic                     step_i,
  input  logic [shs_pkg::KeyW-1:0] levels_i,
  output shs_pkg::shs_ctrl_t       ctrl_o
);
  import shs_pkg::*;

  logic [PeriodW-1:0] fastest_q, slowest_q;
  logic               armed_q, armed_d;
  logic               dir_q, dir_d;
  logic               run_q, run_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [KeyW-1:0]    pressed;
  logic               cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fastest_q <= FastestReset;
      slowest_q <= SlowestReset;
    end else if (cfg_fire) begin
      unique case (shs_reg_e'(cfg_i.index))
        REG_FASTEST: fastest_q <= cfg_i.data;
        REG_SLOWEST: slowest_q <= cfg_i.data;
        default:     fastest_q <= fastest_q;
      endcase
    end
  end

  assign pressed = ~levels_i;

  always_comb begin
    armed_d  = armed_q;
    dir_d    = dir_q;
    run_d    = run_q;
    period_d = period_q;
    if (armed_q && (pressed != '0)) begin
      armed_d = 1'b0;
      priority if (pressed[KeyFwd]) begin
        dir_d = 1'b0;
      end else if (pressed[KeyRev]) begin
        dir_d = 1'b1;
      end else if (pressed[KeyFaster]) begin
        if (period_q > fastest_q) begin
          period_d = period_q - PeriodW'(1);
        end
      end else if (pressed[KeySlower]) begin
        if (period_q < slowest_q) begin
          period_d = period_q + PeriodW'(1);
        end
      end else begin
        run_d = ~run_q;
      end
    end else if (pressed == '0) begin
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b1;
      dir_q    <= 1'b0;
      run_q    <= 1'b1;
      period_q <= PeriodReset;
    end else if (step_i) begin
      armed_q  <= armed_d;
      dir_q    <= dir_d;
      run_q    <= run_d;
      period_q <= period_d;
    end
  end

  assign ctrl_o = '{dir: dir_d, run: run_d, period: period_d};

`ifndef ASSERT_OFF
  a_period_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (period_q == $past(period_q)) || (period_q == $past(period_q) + PeriodW'(1))
               || (period_q == $past(period_q) - PeriodW'(1)))
    else $error("period moved by more than one");
  a_disarm_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && armed_q && (pressed != '0)) |=> !armed_q)
    else $error("key press did not disarm");
  a_rearm_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (pressed == '0)) |=> armed_q)
    else $error("release did not rearm");
`endif

endmodule

### rtl/core/shs_phase_seq.sv
// shs_phase_seq: phase index and dwell counter, coil lookup and result register
// depends on shs_pkg and shs_result_if
module shs_phase_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  shs_pkg::shs_ctrl_t ctrl_i,
  shs_result_if.source       result_o
);
  import shs_pkg::*;

  logic [PhaseW-1:0]  idx_q, idx_d;
  logic [PeriodW-1:0] wait_q, wait_d, wait_inc;
  logic [PhaseW-1:0]  tbl_idx;
  logic [CoilW-1:0]   coils_d, coils_q;
  logic               valid_q, valid_d;
  logic               fwd_q, rev_q, run_q;

  assign tbl_idx  = ctrl_i.dir ? idx_q : (LastPhase - idx_q);
  assign coils_d  = ctrl_i.run ? half_step_coils(tbl_idx) : '0;
  assign wait_inc = wait_q + PeriodW'(1);

  always_comb begin
    idx_d  = idx_q;
    wait_d = '0;
    if (ctrl_i.run) begin
      if (wait_inc >= ctrl_i.period) begin
        idx_d = idx_q + PhaseW'(1);
      end else begin
        wait_d = wait_inc;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      wait_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (step_i) begin
        idx_q  <= idx_d;
        wait_q <= wait_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      coils_q <= coils_d;
      fwd_q   <= ctrl_i.dir;
      rev_q   <= ~ctrl_i.dir;
      run_q   <= ctrl_i.run;
    end
  end

  assign result_o.valid             = valid_q;
  assign result_o.coils             = coils_q;
  assign result_o.forward_led_level = fwd_q;
  assign result_o.reverse_led_level = rev_q;
  assign result_o.running_now       = run_q;

`ifndef ASSERT_OFF
  a_stopped_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !run_q) |-> (coils_q == '0))
    else $error("coils driven while stopped");
  a_running_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && run_q) |-> (($countones(coils_q) == 1) || ($countones(coils_q) == 2)))
    else $error("bad coil pattern while running");
  a_stop_clears_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !ctrl_i.run) |=> (wait_q == '0) && (idx_q == $past(idx_q)))
    else $error("dwell counter not cleared while stopped");
`endif

endmodule

### rtl/core/stepper_half_step_controller_unit.sv
// stepper_half_step_controller_unit: top level of the stepper half-step controller
// depends on shs_pkg, shs_ifs, shs_in_reg, shs_key_ctrl, shs_phase_seq
//
// channel   dir  payload                                        handshake
// tick_i    in   key_levels[4:0]                                valid/ready
// cfg_i     in   index[0], data[7:0]                            valid/ready
// result_o  out  coils[3:0], forward/reverse led, running_now   valid/ready
//
// one item per cycle sustained while the result is not stalled
// the item passes an input register, then key/phase logic into the result register
// reset sets all control state to its reset values; register writes are always taken
// a stalled result holds; one more item waits in the input register
module stepper_half_step_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  shs_tick_if.sink     tick_i,
  shs_cfg_if.sink      cfg_i,
  shs_result_if.source result_o
);
  import shs_pkg::*;

  logic            in_valid;
  logic [KeyW-1:0] levels;
  logic            step;
  shs_ctrl_t       ctrl;

  assign step = in_valid && (!result_o.valid || result_o.ready);

  shs_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_i),
    .adv_i    (step),
    .valid_o  (in_valid),
    .levels_o (levels)
  );

  shs_key_ctrl u_key_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .step_i   (step),
    .levels_i (levels),
    .ctrl_o   (ctrl)
  );

  shs_phase_seq u_phase_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .ctrl_i   (ctrl),
    .result_o (result_o)
  );

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for stepper_half_step_controller_unit
// tick items with key levels go in; a scoreboard class tracks coil phase and keys and checks
// each result item; depends on shs_pkg, shs_ifs, the top level and the rtl below it
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import shs_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [KeyW-1:0] AllReleased = '1;
  localparam logic [KeyW-1:0] AllPressed  = '0;

  typedef struct packed {
    logic [CoilW-1:0] coils;
    logic             fwd_led;
    logic             rev_led;
    logic             running;
  } coil_out_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PULSE
  } stall_mode_e;

  class half_step_scoreboard;
    logic [PeriodW-1:0] fastest;
    logic [PeriodW-1:0] slowest;
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] wait_cnt;
    logic               armed;
    logic               dir;
    logic               running;
    logic [PhaseW-1:0]  phase;
    logic [CoilW-1:0]   coil_seq [8];
    coil_out_t          expected_coils [$];
    int unsigned        errors;

    function new();
      coil_seq = '{4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001};
      fastest  = FastestReset;
      slowest  = SlowestReset;
      period   = PeriodReset;
      wait_cnt = '0;
      armed    = 1'b1;
      dir      = 1'b0;
      running  = 1'b1;
      phase    = '0;
      errors   = 0;
    endfunction

    function void set_reg(shs_reg_e idx, logic [PeriodW-1:0] val);
      if (idx == REG_FASTEST) begin
        fastest = val;
      end else begin
        slowest = val;
      end
    endfunction

    function int pending();
      return expected_coils.size();
    endfunction

    function void note_tick(logic [KeyW-1:0] levels);
      logic [KeyW-1:0]   pressed;
      logic [PhaseW-1:0] idx;
      coil_out_t         exp_out;
      int                k;
      pressed = ~levels;
      if (armed && pressed != '0) begin
        armed = 1'b0;
        k = 0;
        while (!pressed[k]) k++;
        case (k)
          KeyFwd: begin
            dir = 1'b0;
          end
          KeyRev: begin
            dir = 1'b1;
          end
          KeyFaster: begin
            if (period > fastest) period = period - 1'b1;
          end
          KeySlower: begin
            if (period < slowest) period = period + 1'b1;
          end
          default: begin
            running = ~running;
          end
        endcase
      end else if (pressed == '0) begin
        armed = 1'b1;
      end
      idx = dir ? phase : LastPhase - phase;
      exp_out.coils   = running ? coil_seq[idx] : '0;
      exp_out.fwd_led = dir;
      exp_out.rev_led = ~dir;
      exp_out.running = running;
      expected_coils.push_back(exp_out);
      if (running) begin
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= period) begin
          wait_cnt = '0;
          phase = phase + 1'b1;
        end
      end else begin
        wait_cnt = '0;
      end
    endfunction

    task report_mismatch(string field, int got, int want);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $time);
    endtask

    task check_coils(coil_out_t got);
      coil_out_t want;
      if (expected_coils.size() == 0) begin
        report_mismatch("result with nothing pending, coils", got.coils, 0);
        return;
      end
      want = expected_coils.pop_front();
      if (got.coils !== want.coils) report_mismatch("coils", got.coils, want.coils);
      if (got.fwd_led !== want.fwd_led) report_mismatch("forward led", got.fwd_led, want.fwd_led);
      if (got.rev_led !== want.rev_led) report_mismatch("reverse led", got.rev_led, want.rev_led);
      if (got.running !== want.running) report_mismatch("running", got.running, want.running);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  shs_tick_if   tick_if ();
  shs_cfg_if    cfg_if ();
  shs_result_if res_if ();

  stepper_half_step_controller_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  half_step_scoreboard coil_sb;
  int unsigned         cycle_cnt = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         burst_left = 0;
  int unsigned         stall_left = 0;
  stall_mode_e         stall_mode = STALL_NONE;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(STALL_NONE, STALL_PULSE));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  res_if.ready <= 1'b1;
      STALL_COIN:  res_if.ready <= 1'($urandom_range(0, 1));
      STALL_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
      default:     res_if.ready <= (cycle_cnt[2] == 1'b1);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) coil_sb.set_reg(shs_reg_e'(cfg_if.index), cfg_if.data);
      if (tick_if.valid && tick_if.ready) coil_sb.note_tick(tick_if.key_levels);
      if (res_if.valid && res_if.ready) begin
        coil_sb.check_coils('{coils: res_if.coils, fwd_led: res_if.forward_led_level,
                              rev_led: res_if.reverse_led_level,
                              running: res_if.running_now});
      end
    end
  end

  function automatic logic [KeyW-1:0] keys_down(int unsigned k);
    return ~(KeyW'(1) << k);
  endfunction

  function automatic logic [KeyW-1:0] random_press();
    if ($urandom_range(0, 3) != 0) return keys_down($urandom_range(KeyFwd, KeyRun));
    return KeyW'($urandom_range(0, 30));
  endfunction

  task automatic push_tick(input logic [KeyW-1:0] keys);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    ticks_sent++;
    tick_if.valid      <= 1'b1;
    tick_if.key_levels <= keys;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (coil_sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input shs_reg_e idx, input logic [PeriodW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [PeriodW-1:0] fast, input logic [PeriodW-1:0] slow);
    wait_idle();
    write_reg(REG_FASTEST, fast);
    write_reg(REG_SLOWEST, slow);
  endtask

  task automatic run_directed();
    push_tick(AllReleased);
    push_tick(keys_down(KeyFwd));
    push_tick(keys_down(KeyFwd));
    push_tick(AllReleased);
    push_tick(keys_down(KeyRev));
    push_tick(AllReleased);
    push_tick(keys_down(KeyFaster));
    push_tick(AllReleased);
    push_tick(keys_down(KeySlower));
    push_tick(AllReleased);
    push_tick(keys_down(KeySlower));
    push_tick(AllReleased);
    push_tick(keys_down(KeyRun));
    push_tick(AllReleased);
    push_tick(AllReleased);
    push_tick(keys_down(KeyRun));
    push_tick(AllPressed);
    push_tick(AllReleased);
    push_tick(AllPressed);
    push_tick(AllReleased);
    push_tick(keys_down(KeyFwd) & keys_down(KeyRev));
    push_tick(AllReleased);
    push_tick(keys_down(KeyRev) & keys_down(KeySlower) & keys_down(KeyRun));
    push_tick(AllReleased);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned     stop_at;
    int unsigned     pick;
    logic [KeyW-1:0] press;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        repeat ($urandom_range(1, 3)) push_tick(AllReleased);
        press = random_press();
        repeat ($urandom_range(1, 3)) begin
          push_tick(press);
          if ($urandom_range(0, 3) == 0) press = random_press();
        end
      end else if (pick < 9) begin
        repeat ($urandom_range(4, 16)) push_tick(AllReleased);
      end else begin
        repeat ($urandom_range(1, 6)) push_tick(KeyW'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    coil_sb = new();
    rst_ni             <= 1'b0;
    tick_if.valid      <= 1'b0;
    tick_if.key_levels <= AllReleased;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_FASTEST;
    cfg_if.data        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(200);
    set_limits(8'd0, 8'd8);
    run_random(170);
    set_limits(8'd255, 8'd255);
    run_random(140);
    set_limits(8'd200, 8'd2);
    run_random(140);
    set_limits(8'd1, 8'd255);
    run_random(200);
    set_limits(8'd0, 8'd0);
    run_random(100);
    set_limits(8'd3, 8'd12);
    run_random(130);
    wait_idle();

    if (coil_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/shs_pkg.sv
rtl/core/shs_ifs.sv
rtl/core/shs_in_reg.sv
rtl/core/shs_key_ctrl.sv
rtl/core/shs_phase_seq.sv
rtl/core/stepper_half_step_controller_unit.sv
sim/tb_top.sv
